/* hdl/assert_macros.svh */
// Assertion macros shared by the checker files of the heightmap triangle emitter.
// Stand-alone header; no other file is needed to use it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HTE_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define HTE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/hte_pkg.sv */
// Package of the heightmap triangle emitter: field widths, register codes,
// vertex order and the command, status and vertex structs. No dependencies.
`default_nettype none

package hte_pkg;

	localparam int DEF_MAX_SIDE = 1025;

	localparam int H_W    = 16;             // height sample
	localparam int SIDE_W = 11;             // page side and grid counters
	localparam int PG_W   = 8;              // page index
	localparam int SC_W   = 16;             // Q8.8 scale
	localparam int GX_W   = PG_W + SIDE_W;  // global grid coordinate
	localparam int VX_W   = GX_W + SC_W;    // scaled x or z coordinate
	localparam int VY_W   = 32;             // scaled height
	localparam int YP_W   = H_W + SC_W + 1; // signed height product before truncation
	localparam int IDX_W  = 3;              // configuration register index
	localparam int CFG_W  = 16;             // configuration write data

	localparam logic [SIDE_W-1:0] MIN_SIDE = SIDE_W'(2);

	typedef enum logic [IDX_W-1:0] {
		REG_PAGE_SIDE,
		REG_PAGE_COL,
		REG_PAGE_ROW,
		REG_SCALE_X,
		REG_SCALE_Y,
		REG_SCALE_Z
	} hte_reg_t;

	// Six vertices of a cell, in emission order.
	typedef enum logic [2:0] {
		VTX_UPLEFT,
		VTX_LEFT_A,
		VTX_UP_A,
		VTX_UP_B,
		VTX_LEFT_B,
		VTX_CUR
	} hte_vtx_t;

	typedef struct packed {
		logic     accept; // sample transfer this cycle
		logic     load;   // row entry is back, update neighbors
		logic     mul;    // form scaled base coordinates
		logic     emit;   // load the output register
		hte_vtx_t vidx;   // vertex to load
	} hte_cmd_t;

	typedef struct packed {
		logic cell_done; // current sample completes a cell
	} hte_stat_t;

	typedef struct packed {
		logic [VX_W-1:0]        vert_x;
		logic signed [VY_W-1:0] vert_y;
		logic [VX_W-1:0]        vert_z;
		logic                   cell_end;
		logic                   page_end;
	} hte_vert_t;

endpackage

`default_nettype wire

/* hdl/hte_if.sv */
// Channel interfaces of the heightmap triangle emitter: samples in, vertices out,
// configuration writes. Depends on hte_pkg.
`default_nettype none

interface hte_in_if;
	logic                               valid;
	logic                               ready;
	logic signed [hte_pkg::H_W-1:0]     height;
	modport source (output valid, output height, input ready);
	modport sink (input valid, input height, output ready);
endinterface

interface hte_out_if;
	logic                               valid;
	logic                               ready;
	logic [hte_pkg::VX_W-1:0]           vert_x;
	logic signed [hte_pkg::VY_W-1:0]    vert_y;
	logic [hte_pkg::VX_W-1:0]           vert_z;
	logic                               cell_end;
	logic                               page_end;
	modport source (output valid, output vert_x, output vert_y, output vert_z,
		output cell_end, output page_end, input ready);
	modport sink (input valid, input vert_x, input vert_y, input vert_z,
		input cell_end, input page_end, output ready);
endinterface

interface hte_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [hte_pkg::IDX_W-1:0]          index;
	logic [hte_pkg::CFG_W-1:0]          data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* hdl/hte_ram.sv */
// Generic single-port RAM with registered read, used for the row store.
// No dependencies.
`default_nettype none

module hte_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1025
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[addr];
		end
	end

endmodule

`default_nettype wire

/* hdl/hte_ctrl.sv */
// Controller of the heightmap triangle emitter: sequences one sample through
// row read, base multiply and six vertex loads. Depends on hte_pkg.
`default_nettype none

module hte_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  hte_pkg::hte_stat_t stat,
	output hte_pkg::hte_cmd_t  cmd
);
	import hte_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD,
		ST_MUL,
		ST_EMIT
	} state_t;

	state_t   state_q;
	hte_vtx_t vidx_q;
	logic     ovalid_q;
	logic     out_free;

	always_comb begin
		in_ready   = (state_q == ST_IDLE);
		out_free   = !ovalid_q || out_ready;
		cmd.accept = in_ready && in_valid;
		cmd.load   = (state_q == ST_LOAD);
		cmd.mul    = (state_q == ST_MUL);
		cmd.emit   = (state_q == ST_EMIT) && out_free;
		cmd.vidx   = vidx_q;
		out_valid  = ovalid_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			vidx_q   <= VTX_UPLEFT;
			ovalid_q <= 1'b0;
		end else begin
			if (cmd.emit) begin
				ovalid_q <= 1'b1;
			end else if (out_ready) begin
				ovalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd.accept) begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					state_q <= stat.cell_done ? ST_MUL : ST_IDLE;
				end
				ST_MUL: begin
					state_q <= ST_EMIT;
					vidx_q  <= VTX_UPLEFT;
				end
				ST_EMIT: begin
					if (out_free) begin
						if (vidx_q == VTX_CUR) begin
							state_q <= ST_IDLE;
							vidx_q  <= VTX_UPLEFT;
						end else begin
							vidx_q <= hte_vtx_t'(vidx_q + 3'd1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

/* hdl/hte_dp.sv */
// Datapath of the heightmap triangle emitter: configuration registers, grid
// counters, row store, multipliers and the output register. Depends on hte_pkg,
// hte_if and hte_ram.
`default_nettype none

module hte_dp #(
	parameter int MAX_SIDE = hte_pkg::DEF_MAX_SIDE
) (
	input  logic                            clk,
	input  logic                            arst_n,
	hte_cfg_if.sink                         cfg,
	input  logic signed [hte_pkg::H_W-1:0]  height,
	input  hte_pkg::hte_cmd_t               cmd,
	output hte_pkg::hte_stat_t              stat,
	output hte_pkg::hte_vert_t              vert
);
	import hte_pkg::*;

	localparam int ADDR_W = $clog2(MAX_SIDE);

	// Configuration registers.
	logic [SIDE_W-1:0] page_side_q;
	logic [PG_W-1:0]   page_col_q;
	logic [PG_W-1:0]   page_row_q;
	logic [SC_W-1:0]   scale_x_q;
	logic [SC_W-1:0]   scale_y_q;
	logic [SC_W-1:0]   scale_z_q;

	// Grid position and neighbor samples.
	logic [SIDE_W-1:0]     col_q, row_q;
	logic signed [H_W-1:0] left_q, upleft_q;

	// Per-sample working registers.
	logic [SIDE_W-1:0]     x_q, z_q;
	logic signed [H_W-1:0] h_q, ul_q, lf_q, up_q;
	logic                  cell_q, last_q;
	logic [GX_W-1:0]       gxb_q, gzb_q, gx0_q, gz0_q;
	logic [VX_W-1:0]       x0_q, z0_q;
	hte_vert_t             vert_q;

	logic [SIDE_W-1:0]     side, cx, rz, nx, nz;
	logic [ADDR_W-1:0]     ram_addr;
	logic [H_W-1:0]        ram_rdata;
	logic signed [H_W-1:0] hsel;
	logic                  xsel, zsel;
	logic signed [YP_W-1:0] prod_y;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_side_q <= SIDE_W'(513);
			page_col_q  <= '0;
			page_row_q  <= '0;
			scale_x_q   <= SC_W'(256);
			scale_y_q   <= SC_W'(256);
			scale_z_q   <= SC_W'(256);
		end else if (cfg.valid) begin
			case (hte_reg_t'(cfg.index))
				REG_PAGE_SIDE: page_side_q <= cfg.data[SIDE_W-1:0];
				REG_PAGE_COL:  page_col_q  <= cfg.data[PG_W-1:0];
				REG_PAGE_ROW:  page_row_q  <= cfg.data[PG_W-1:0];
				REG_SCALE_X:   scale_x_q   <= cfg.data[SC_W-1:0];
				REG_SCALE_Y:   scale_y_q   <= cfg.data[SC_W-1:0];
				REG_SCALE_Z:   scale_z_q   <= cfg.data[SC_W-1:0];
				default: ;
			endcase
		end
	end

	// Side in use, then the position of this sample and of the next one.
	always_comb begin
		if (page_side_q < MIN_SIDE) begin
			side = MIN_SIDE;
		end else if (32'(page_side_q) > 32'(MAX_SIDE)) begin
			side = SIDE_W'(MAX_SIDE);
		end else begin
			side = page_side_q;
		end
		cx = col_q;
		rz = row_q;
		if (cx >= side) begin
			cx = '0;
			rz = row_q + SIDE_W'(1);
		end
		if (rz >= side) begin
			rz = '0;
		end
		nx = cx + SIDE_W'(1);
		nz = rz;
		if (nx >= side) begin
			nx = '0;
			nz = rz + SIDE_W'(1);
			if (nz >= side) begin
				nz = '0;
			end
		end
	end

	// The row entry is read when the sample arrives and rewritten in the next cycle.
	assign ram_addr = cmd.load ? ADDR_W'(x_q) : ADDR_W'(cx);

	hte_ram #(
		.WIDTH(H_W),
		.DEPTH(MAX_SIDE)
	) u_row_ram (
		.clk  (clk),
		.we   (cmd.load),
		.re   (cmd.accept),
		.addr (ram_addr),
		.wdata(h_q),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			left_q   <= '0;
			upleft_q <= '0;
			cell_q   <= 1'b0;
		end else begin
			if (cmd.accept) begin
				col_q  <= nx;
				row_q  <= nz;
				cell_q <= (cx != '0) && (rz != '0);
			end
			if (cmd.load) begin
				upleft_q <= $signed(ram_rdata);
				left_q   <= h_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			x_q    <= cx;
			z_q    <= rz;
			h_q    <= height;
			last_q <= (cx == side - SIDE_W'(1)) && (rz == side - SIDE_W'(1));
			gxb_q  <= GX_W'(page_col_q) * GX_W'(side);
			gzb_q  <= GX_W'(page_row_q) * GX_W'(side);
		end
		if (cmd.load) begin
			ul_q  <= upleft_q;
			lf_q  <= left_q;
			up_q  <= $signed(ram_rdata);
			gx0_q <= gxb_q + GX_W'(x_q - SIDE_W'(1));
			gz0_q <= gzb_q + GX_W'(z_q - SIDE_W'(1));
		end
		if (cmd.mul) begin
			x0_q <= VX_W'(gx0_q) * VX_W'(scale_x_q);
			z0_q <= VX_W'(gz0_q) * VX_W'(scale_z_q);
		end
		if (cmd.emit) begin
			vert_q.vert_x   <= xsel ? x0_q + VX_W'(scale_x_q) : x0_q;
			vert_q.vert_y   <= prod_y[VY_W-1:0];
			vert_q.vert_z   <= zsel ? z0_q + VX_W'(scale_z_q) : z0_q;
			vert_q.cell_end <= (cmd.vidx == VTX_CUR);
			vert_q.page_end <= (cmd.vidx == VTX_CUR) && last_q;
		end
	end

	// Corner of the cell that the vertex sits on.
	always_comb begin
		case (cmd.vidx)
			VTX_UPLEFT: begin xsel = 1'b0; zsel = 1'b0; hsel = ul_q; end
			VTX_LEFT_A: begin xsel = 1'b0; zsel = 1'b1; hsel = lf_q; end
			VTX_UP_A:   begin xsel = 1'b1; zsel = 1'b0; hsel = up_q; end
			VTX_UP_B:   begin xsel = 1'b1; zsel = 1'b0; hsel = up_q; end
			VTX_LEFT_B: begin xsel = 1'b0; zsel = 1'b1; hsel = lf_q; end
			VTX_CUR:    begin xsel = 1'b1; zsel = 1'b1; hsel = h_q; end
			default:    begin xsel = 1'b0; zsel = 1'b0; hsel = h_q; end
		endcase
	end

	assign prod_y = hsel * $signed({1'b0, scale_y_q});

	assign stat.cell_done = cell_q;
	assign vert           = vert_q;

endmodule

`default_nettype wire

/* hdl/heightmap_triangle_emitter.sv */
// Heightmap triangle emitter, top level. Depends on hte_pkg, hte_if, hte_ctrl, hte_dp.
// Flow: a sample on the first row or column passes the row read and write-back; one
// that completes a cell also takes the base multiply and six vertex loads over one
// output register. A new sample is taken only once the last one is through its steps.
// Reset: asynchronous, active low; counters and neighbors clear, registers take defaults.
`default_nettype none

// The block reads a square page of height samples in row-major order. A
// single-port row store keeps the previous row; the left and upper-left
// samples live in registers. Each sample with column and row both nonzero
// closes one grid cell, and six vertices leave as two triangles.
//
// The controller walks each sample through up to four steps: take the sample and
// launch the row read, update the neighbors and write the row entry back, and,
// only if the sample closes a cell, multiply the cell's base coordinates by the
// axis scales, then load six vertices one by one into the output register as it
// frees up. The output register stays loaded while a new sample transfer is
// taken, so the last vertex of one cell overlaps the start of the next sample.
//
// Configuration writes are always accepted and take effect at once; they are
// meant to land only while the block is idle.
module heightmap_triangle_emitter #(
	parameter int MAX_SIDE = hte_pkg::DEF_MAX_SIDE
) (
	input  logic      clk,
	input  logic      arst_n,
	hte_in_if.sink    samples,
	hte_out_if.source verts,
	hte_cfg_if.sink   cfg
);
	import hte_pkg::*;

	hte_cmd_t  cmd;
	hte_stat_t stat;
	hte_vert_t vert;

	// Sequencer: owns the sample and vertex handshakes and the vertex counter.
	hte_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (samples.valid),
		.in_ready (samples.ready),
		.out_valid(verts.valid),
		.out_ready(verts.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Arithmetic, storage and configuration registers.
	hte_dp #(
		.MAX_SIDE(MAX_SIDE)
	) u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg),
		.height(samples.height),
		.cmd   (cmd),
		.stat  (stat),
		.vert  (vert)
	);

	// The output register's contents drive the vertex channel directly.
	assign verts.vert_x   = vert.vert_x;
	assign verts.vert_y   = vert.vert_y;
	assign verts.vert_z   = vert.vert_z;
	assign verts.cell_end = vert.cell_end;
	assign verts.page_end = vert.page_end;

endmodule

`default_nettype wire

/* hdl/hte_checker.sv */
// Port-level checks of the heightmap triangle emitter and their bind.
// Depends on assert_macros.svh and heightmap_triangle_emitter.
`default_nettype none

`include "assert_macros.svh"

module hte_checker (
	input logic clk,
	input logic arst_n,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic cell_end,
	input logic page_end,
	input logic cfg_ready
);

	// The page ends only on the last vertex of a cell.
	`HTE_ASSERT_IMPL(a_page_end, clk, arst_n, out_valid && page_end, cell_end, "page_end alone")

	// While a cell is still being emitted no new sample transfer is offered.
	`HTE_ASSERT_IMPL(a_mid_cell, clk, arst_n, out_valid && !cell_end, !in_ready, "sample mid-cell")

	// Configuration writes never stall.
	`HTE_ASSERT_IMPL(a_cfg_ready, clk, arst_n, 1'b1, cfg_ready, "configuration port stalled")

	// A stalled vertex stays offered.
	`HTE_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid, "vertex withdrawn")

endmodule

bind heightmap_triangle_emitter hte_checker u_hte_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_ready (samples.ready),
	.out_valid(verts.valid),
	.out_ready(verts.ready),
	.cell_end (verts.cell_end),
	.page_end (verts.page_end),
	.cfg_ready(cfg.ready)
);

`default_nettype wire

/* tb/heightmap_triangle_emitter_test.sv */
// Self-checking testbench of heightmap_triangle_emitter: streams height samples in,
// predicts every vertex in a built-in model and checks the vertex stream field by field.
// Depends on hte_pkg, the channel interfaces in hte_if and the block itself.
module heightmap_triangle_emitter_test;
	import hte_pkg::*;

	localparam int CLK_PERIOD      = 10;
	localparam int RESET_CYCLES    = 9;
	localparam int MAX_SIDE        = DEF_MAX_SIDE;
	// Margin for the block to run dry: it covers the wait for a cell's first
	// vertex and the time a sample that closes no cell keeps the block busy.
	localparam int SETTLE_CYCLES   = 16;
	// Long stall of the vertex receiver, so that the block fills and stops
	// taking samples.
	localparam int HOLD_OFF_CYCLES = 200;
	localparam int RANDOM_ITEMS    = 150;
	// Samples sent on the first row at the reset settings.
	localparam int DEFAULT_ROW_ITEMS = 12;
	// Samples sent on the first row at the largest side.
	localparam int WIDE_ROW_ITEMS    = 40;
	// Slowest correct run: under 600 samples, each with six vertices that
	// may each wait out the longest receiver gap, plus the longest sender gap,
	// the work on the sample and a settle time. The timeout allows about six
	// times that.
	localparam int TIMEOUT_CYCLES  = 1_000_000;

	// Register indexes that the block does not decode; writes to them must
	// leave every setting unchanged.
	localparam logic [IDX_W-1:0] UNUSED_REG_LO = 3'd6;
	localparam logic [IDX_W-1:0] UNUSED_REG_HI = 3'd7;

	logic clk = 1'b0;
	logic arst_n;

	hte_in_if  sample_ch();
	hte_out_if vert_ch();
	hte_cfg_if cfg_ch();

	heightmap_triangle_emitter i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.samples(sample_ch),
		.verts  (vert_ch),
		.cfg    (cfg_ch)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// ------------------------------------------------------------------
	// Model of the block. The register copies start at their reset values;
	// reset is applied only once, at the start of the run.
	// ------------------------------------------------------------------
	logic [SIDE_W-1:0] pg_side = SIDE_W'(513);
	logic [PG_W-1:0]   pg_col  = '0;
	logic [PG_W-1:0]   pg_row  = '0;
	logic [SC_W-1:0]   sc_x    = SC_W'(256);
	logic [SC_W-1:0]   sc_y    = SC_W'(256);
	logic [SC_W-1:0]   sc_z    = SC_W'(256);

	// Previous row of samples plus the two neighbors of the incoming one.
	logic [H_W-1:0] row_hist [0:MAX_SIDE-1];
	logic [H_W-1:0] prev_left   = '0;
	logic [H_W-1:0] prev_upleft = '0;
	int unsigned    col_cnt     = 0;
	int unsigned    row_cnt     = 0;

	// Vertices predicted but not yet seen, oldest first.
	hte_vert_t expected_verts[$];

	int unsigned heights_sent = 0;
	int unsigned verts_seen   = 0;
	int unsigned mismatches   = 0;

	// Idling controls, set by the tests and read by the channel drivers.
	bit source_gaps   = 1'b0;
	bit sink_gaps     = 1'b0;
	bit sink_hold_off = 1'b0;

	// Mostly short gaps, now and then a long one.
	function automatic int unsigned pick_gap();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 3);
	endfunction

	// Heights lean on the extremes and on the values around zero.
	function automatic logic [H_W-1:0] rand_height();
		case ($urandom_range(0, 11))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'hFFFF;
			3: return 16'h0000;
			default: return H_W'($urandom());
		endcase
	endfunction

	function automatic logic [SC_W-1:0] rand_scale();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return SC_W'($urandom());
		endcase
	endfunction

	// One scaled vertex. The products are exact: x and z are unsigned and
	// fit in 35 bits, the height product is signed and kept to 32 bits.
	function automatic void emit_vertex(input int unsigned side, input int unsigned xi,
		input int unsigned zi, input logic [H_W-1:0] h, input bit last_of_cell,
		input bit last_of_page);
		hte_vert_t   v;
		logic [63:0] gx;
		logic [63:0] gz;
		longint      hy;
		gx = 64'(pg_col) * side + xi;
		gz = 64'(pg_row) * side + zi;
		hy = longint'($signed(h)) * longint'(sc_y);
		v.vert_x   = VX_W'(gx * sc_x);
		v.vert_y   = VY_W'(hy);
		v.vert_z   = VX_W'(gz * sc_z);
		v.cell_end = last_of_cell;
		v.page_end = last_of_page;
		expected_verts = {expected_verts, v};
	endfunction

	// Advances the model by one accepted sample and queues the six vertices
	// of the cell that it closes, if any.
	function automatic void triangulate_sample(input logic [H_W-1:0] h);
		int unsigned    side;
		int unsigned    x;
		int unsigned    z;
		logic [H_W-1:0] above;
		logic [H_W-1:0] diag;
		logic [H_W-1:0] beside;
		bit             last;
		side = pg_side;
		if (side < MIN_SIDE)
			side = MIN_SIDE;
		if (side > MAX_SIDE)
			side = MAX_SIDE;
		// A side that shrank under the counters wraps them here.
		if (col_cnt >= side) begin
			col_cnt = 0;
			row_cnt++;
		end
		if (row_cnt >= side)
			row_cnt = 0;
		x = col_cnt;
		z = row_cnt;
		above  = row_hist[x];
		diag   = prev_upleft;
		beside = prev_left;
		if (x >= 1 && z >= 1) begin
			last = (x == side - 1) && (z == side - 1);
			emit_vertex(side, x - 1, z - 1, diag, 1'b0, 1'b0);
			emit_vertex(side, x - 1, z, beside, 1'b0, 1'b0);
			emit_vertex(side, x, z - 1, above, 1'b0, 1'b0);
			emit_vertex(side, x, z - 1, above, 1'b0, 1'b0);
			emit_vertex(side, x - 1, z, beside, 1'b0, 1'b0);
			emit_vertex(side, x, z, h, 1'b1, last);
		end
		prev_upleft = above;
		prev_left   = h;
		row_hist[x] = h;
		x++;
		if (x >= side) begin
			x = 0;
			z++;
			if (z >= side)
				z = 0;
		end
		col_cnt = x;
		row_cnt = z;
	endfunction

	// ------------------------------------------------------------------
	// Channel drivers. Inputs change only with nonblocking assignments at
	// the rising edge, and handshakes are judged on the values seen just
	// before that edge.
	// ------------------------------------------------------------------
	task automatic report_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		$display("ERROR vertex %0d at %0t: %s got %0h, expected %0h",
			verts_seen, $realtime, what, got, want);
		mismatches++;
	endtask

	// Offers one height sample, with a random gap in front of it when the
	// test asks for one, and feeds the model once the transfer takes place.
	// The valid stays high for the next call, so back-to-back samples
	// stream without a bubble.
	task automatic send_sample(input logic [H_W-1:0] h);
		int unsigned idle_len;
		if (cfg_ch.valid)
			cfg_ch.valid <= 1'b0;
		if (source_gaps && $urandom_range(0, 3) == 0) begin
			sample_ch.valid <= 1'b0;
			idle_len = pick_gap();
			repeat (idle_len) @(posedge clk);
		end
		sample_ch.valid  <= 1'b1;
		sample_ch.height <= h;
		do
			@(posedge clk);
		while (!sample_ch.ready);
		triangulate_sample(h);
		heights_sent++;
	endtask

	task automatic send_square(input logic [H_W-1:0] a, input logic [H_W-1:0] b,
		input logic [H_W-1:0] c, input logic [H_W-1:0] d);
		send_sample(a);
		send_sample(b);
		send_sample(c);
		send_sample(d);
	endtask

	// Sends random samples until the model stands at the start of a page.
	task automatic finish_page();
		while (col_cnt != 0 || row_cnt != 0)
			send_sample(rand_height());
	endtask

	// Stops offering samples and waits until every predicted vertex has
	// arrived, then lets the block's pipeline run dry. Samples that close no
	// cell leave nothing in the queue, so the settle time matters.
	task automatic quiesce();
		sample_ch.valid <= 1'b0;
		while (expected_verts.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One register write; the caller makes sure the block is idle. The model
	// decodes the index itself and drops indexes that name no register.
	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= data;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		case (idx)
			REG_PAGE_SIDE: pg_side = data[SIDE_W-1:0];
			REG_PAGE_COL:  pg_col  = data[PG_W-1:0];
			REG_PAGE_ROW:  pg_row  = data[PG_W-1:0];
			REG_SCALE_X:   sc_x    = data;
			REG_SCALE_Y:   sc_y    = data;
			REG_SCALE_Z:   sc_z    = data;
			default: ;
		endcase
	endtask

	// Vertex receiver: ready is mostly high, drops for random gaps when the
	// test allows them, and holds off for a long stretch on request.
	initial begin : vertex_sink
		int unsigned idle_len;
		vert_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (sink_hold_off) begin
				vert_ch.ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				sink_hold_off = 1'b0;
				vert_ch.ready <= 1'b1;
			end else if (sink_gaps && $urandom_range(0, 3) == 0) begin
				vert_ch.ready <= 1'b0;
				idle_len = pick_gap();
				repeat (idle_len) @(posedge clk);
				vert_ch.ready <= 1'b1;
			end else begin
				vert_ch.ready <= 1'b1;
			end
		end
	end

	// Every vertex transfer is matched against the oldest prediction.
	always @(posedge clk) begin : check_vertex
		hte_vert_t want;
		if (arst_n && vert_ch.valid && vert_ch.ready) begin
			if (expected_verts.size() == 0) begin
				report_mismatch("vertex with none expected", vert_ch.vert_x, '0);
			end else begin
				want = expected_verts.pop_front();
				if (vert_ch.vert_x !== want.vert_x)
					report_mismatch("vert_x", vert_ch.vert_x, want.vert_x);
				if (vert_ch.vert_y !== want.vert_y)
					report_mismatch("vert_y", vert_ch.vert_y, want.vert_y);
				if (vert_ch.vert_z !== want.vert_z)
					report_mismatch("vert_z", vert_ch.vert_z, want.vert_z);
				if (vert_ch.cell_end !== want.cell_end)
					report_mismatch("cell_end", vert_ch.cell_end, want.cell_end);
				if (vert_ch.page_end !== want.page_end)
					report_mismatch("page_end", vert_ch.page_end, want.page_end);
			end
			verts_seen++;
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Runs on the reset settings: part of a 513-sample first row goes in,
	// so no cell may close yet. Leaves the model on row 0, column 12.
	task automatic test_reset_defaults();
		source_gaps = 1'b1;
		sink_gaps   = 1'b1;
		repeat (DEFAULT_ROW_ITEMS) send_sample(rand_height());
	endtask

	// Shrinks the side in the middle of a page, below the column counter:
	// the column wraps at once, the row moves on, and the remaining rows
	// close cells at the reset scales and page indexes.
	task automatic test_side_shrink_mid_page();
		quiesce();
		write_reg(REG_PAGE_SIDE, 16'd3);
		finish_page();
	endtask

	// Smallest pages with the field extremes: full-range heights, all-ones
	// and zero scales, the last page index, side values below the minimum (one
	// with stray upper data bits), and writes to undecoded indexes.
	task automatic test_field_extremes();
		quiesce();
		source_gaps = 1'b0;
		sink_gaps   = 1'b0;
		// Side 1 is clamped to 2; the upper data bits must be dropped.
		write_reg(REG_PAGE_SIDE, 16'hF801);
		write_reg(REG_PAGE_COL, 16'hFFFF);
		write_reg(REG_PAGE_ROW, 16'h00FF);
		write_reg(REG_SCALE_X, 16'hFFFF);
		write_reg(REG_SCALE_Y, 16'hFFFF);
		write_reg(REG_SCALE_Z, 16'hFFFF);
		send_square(16'h8000, 16'h7FFF, 16'hFFFF, 16'h0000);
		send_square(16'h7FFF, 16'h0000, 16'h8000, 16'h0001);
		quiesce();
		// Zero scales and a side of 0, which is clamped to 2 as well.
		write_reg(REG_SCALE_X, 16'h0000);
		write_reg(REG_SCALE_Y, 16'h0000);
		write_reg(REG_SCALE_Z, 16'h0000);
		write_reg(REG_PAGE_SIDE, 16'h0000);
		write_reg(REG_PAGE_COL, 16'h0000);
		write_reg(REG_PAGE_ROW, 16'h0000);
		send_square(16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF);
		quiesce();
		// These must change nothing: the next page still has side 2 and
		// zero scales.
		write_reg(UNUSED_REG_LO, 16'hFFFF);
		write_reg(UNUSED_REG_HI, 16'hFFFF);
		send_square(16'h5A5A, 16'hA5A5, 16'h8000, 16'h7FFF);
		quiesce();
		write_reg(REG_PAGE_SIDE, 16'hF803);
		write_reg(REG_SCALE_X, 16'h0001);
		write_reg(REG_SCALE_Y, 16'h8000);
		write_reg(REG_SCALE_Z, 16'h0100);
		source_gaps = 1'b1;
		sink_gaps   = 1'b1;
		repeat (9) send_sample(rand_height());
		finish_page();
	endtask

	// The largest side setting (an out-of-range value clamped to the store
	// depth), the last page indexes and full scales. Part of the first row
	// goes in; a smaller side then wraps the column, a few samples on the
	// next row close wide cells, and a side of 2 closes the page early.
	task automatic test_largest_side();
		quiesce();
		write_reg(REG_PAGE_SIDE, 16'h07FF);
		write_reg(REG_PAGE_COL, 16'h00FF);
		write_reg(REG_PAGE_ROW, 16'hFFFF);
		write_reg(REG_SCALE_X, 16'hFFFF);
		write_reg(REG_SCALE_Y, 16'hFFFF);
		write_reg(REG_SCALE_Z, 16'hFFFF);
		repeat (WIDE_ROW_ITEMS) send_sample(rand_height());
		quiesce();
		write_reg(REG_PAGE_SIDE, CFG_W'(WIDE_ROW_ITEMS));
		repeat (3) send_sample(rand_height());
		quiesce();
		write_reg(REG_PAGE_SIDE, 16'd2);
		finish_page();
	endtask

	// The receiver stalls for a long stretch while samples keep coming, so
	// the block fills up and has to stall its own input.
	task automatic test_output_hold_off();
		quiesce();
		write_reg(REG_PAGE_SIDE, 16'd4);
		write_reg(REG_PAGE_COL, 16'd1);
		write_reg(REG_PAGE_ROW, 16'd2);
		write_reg(REG_SCALE_X, 16'h0180);
		write_reg(REG_SCALE_Y, 16'h0100);
		write_reg(REG_SCALE_Z, 16'h0040);
		source_gaps   = 1'b0;
		sink_gaps     = 1'b0;
		sink_hold_off = 1'b1;
		repeat (32) send_sample(rand_height());
		finish_page();
	endtask

	// Whole pages on random settings, mostly small sides. Idling is switched
	// per phase, and now and then the sender pauses mid-page until every
	// vertex has come back.
	task automatic test_random_pages();
		int unsigned first_count;
		int unsigned side_val;
		int unsigned side_use;
		int unsigned n;
		int unsigned k;
		bit          pause_mid;
		first_count = heights_sent;
		while (heights_sent - first_count < RANDOM_ITEMS) begin
			quiesce();
			source_gaps = ($urandom_range(0, 2) != 0);
			sink_gaps   = ($urandom_range(0, 2) != 0);
			if ($urandom_range(0, 9) < 7)
				side_val = $urandom_range(2, 6);
			else if ($urandom_range(0, 1) == 0)
				side_val = $urandom_range(7, 12);
			else
				side_val = $urandom_range(0, 1);
			side_use = (side_val < 2) ? 2 : side_val;
			write_reg(REG_PAGE_SIDE, {5'($urandom()), SIDE_W'(side_val)});
			if ($urandom_range(0, 3) != 0)
				write_reg(REG_PAGE_COL, CFG_W'($urandom()));
			if ($urandom_range(0, 3) != 0)
				write_reg(REG_PAGE_ROW, CFG_W'($urandom()));
			if ($urandom_range(0, 3) != 0)
				write_reg(REG_SCALE_X, rand_scale());
			if ($urandom_range(0, 3) != 0)
				write_reg(REG_SCALE_Y, rand_scale());
			if ($urandom_range(0, 3) != 0)
				write_reg(REG_SCALE_Z, rand_scale());
			n = $urandom_range(1, 2) * side_use * side_use;
			pause_mid = ($urandom_range(0, 3) == 0);
			for (k = 0; k < n; k++) begin
				if (pause_mid && k == n / 2)
					quiesce();
				send_sample(rand_height());
			end
		end
	endtask

	initial begin : run_tests
		arst_n           = 1'b0;
		sample_ch.valid  = 1'b0;
		sample_ch.height = '0;
		cfg_ch.valid     = 1'b0;
		cfg_ch.index     = '0;
		cfg_ch.data      = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_defaults();
		test_side_shrink_mid_page();
		test_field_extremes();
		test_largest_side();
		test_output_hold_off();
		test_random_pages();

		// Everything predicted must have come back, and nothing may follow.
		quiesce();
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin : watchdog
		#(TIMEOUT_CYCLES * CLK_PERIOD);
		$display("timeout: %0d vertices still expected", expected_verts.size());
		$display("*** FAILED ***");
		$finish;
	end

endmodule
